FILE: hdl/multichannel_boxcar_decimator_defines.svh
// Assertion macros for the multichannel boxcar decimator checker.
// No dependencies; included by the checker file only.
`ifndef MULTICHANNEL_BOXCAR_DECIMATOR_DEFINES_SVH
`define MULTICHANNEL_BOXCAR_DECIMATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MBD_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("boxcar decimator check failed");

// next-cycle implication, disabled during reset
`define MBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("boxcar decimator check failed");

// state seen on the cycle after reset is sampled high
`define MBD_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("boxcar decimator reset check failed");

`endif

FILE: hdl/mbd_pkg.sv
// Shared types and constants of the multichannel boxcar decimator.
// No dependencies; used by mbd_rsp_if, the top level, the checker and the bench.
`timescale 1ns / 1ps
`default_nettype none

package mbd_pkg;

   localparam int REG_COUNT     = 8;
   localparam int WIN_BITS      = 7;
   localparam int WIN_MAX       = (1 << WIN_BITS) - 1;
   localparam int CH_FIELD_BITS = 3;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [WIN_BITS-1:0] WINDOW_RESET [REG_COUNT] = '{
      7'd100, 7'd50, 7'd20, 7'd10, 7'd4, 7'd2, 7'd1, 7'd1
   };

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_LOAD,
      SEQ_ADD,
      SEQ_CHECK,
      SEQ_DIV,
      SEQ_PUSH,
      SEQ_NEXT,
      SEQ_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic take_frame;
      logic load_ch;
      logic clear_ch;
      logic add_step;
      logic commit;
      logic emit;
      logic push_out;
      logic pend_load;
      logic flush;
      logic next_ch;
   } seq_ctl_type;

endpackage

`default_nettype wire

FILE: hdl/mbd_req_if.sv
// Request channel of the boxcar decimator: one frame of channel samples.
// Depends on nothing but its SAMPLE_BITS parameter.
`timescale 1ns / 1ps
`default_nettype none

interface mbd_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_ch0;
   logic signed [SAMPLE_BITS-1:0] sample_ch1;
   logic signed [SAMPLE_BITS-1:0] sample_ch2;
   logic signed [SAMPLE_BITS-1:0] sample_ch3;
   logic signed [SAMPLE_BITS-1:0] sample_ch4;
   logic signed [SAMPLE_BITS-1:0] sample_ch5;
   logic signed [SAMPLE_BITS-1:0] sample_ch6;
   logic signed [SAMPLE_BITS-1:0] sample_ch7;

   modport source (
      output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
             sample_ch4, sample_ch5, sample_ch6, sample_ch7,
      input  ready
   );

   modport sink (
      input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
             sample_ch4, sample_ch5, sample_ch6, sample_ch7,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/mbd_rsp_if.sv
// Response channel of the boxcar decimator: one channel average per transfer.
// Depends on mbd_pkg for the channel field width.
`timescale 1ns / 1ps
`default_nettype none

interface mbd_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   import mbd_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [CH_FIELD_BITS-1:0]      channel;
   logic signed [SAMPLE_BITS-1:0] average;
   logic                          last;

   modport source (
      output valid, channel, average, last,
      input  ready
   );

   modport sink (
      input  valid, channel, average, last,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/mbd_serial_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the boxcar decimator top level.
`timescale 1ns / 1ps
`default_nettype none

module mbd_serial_div #(
   parameter int NUM_BITS = 24,
   parameter int DEN_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff;
   logic [CNT_BITS-1:0] left_ff;
   logic [NUM_BITS-1:0] quo_ff;
   logic [DEN_BITS-1:0] rem_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic [DEN_BITS:0]   rem_try;
   logic                fits;
   logic [DEN_BITS:0]   rem_in;

   // shift the next numerator bit into the partial remainder
   assign rem_try = {rem_ff, quo_ff[NUM_BITS-1]};
   assign fits    = rem_try >= {1'b0, den_ff};
   assign rem_in  = fits ? (rem_try - {1'b0, den_ff}) : rem_try;

   assign done     = busy_ff && (left_ff == '0);
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         left_ff <= CNT_BITS'(NUM_BITS);
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         left_ff <= left_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff && (left_ff != '0)) begin
         quo_ff <= {quo_ff[NUM_BITS-2:0], fits};
         rem_ff <= rem_in[DEN_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/multichannel_boxcar_decimator.sv
// Multichannel boxcar-average decimator, top level.
// Depends on mbd_pkg, mbd_req_if, mbd_rsp_if and mbd_serial_div.
//
// Usage:
//   req_bus takes one frame per request: one signed sample for each channel.
//   rsp_bus returns one result per channel whose window completes in that
//   frame, in ascending channel order; last marks the final result of a frame.
//   csr_we/csr_index/csr_wdata write the per-channel window (0 disables);
//   write only while the block is idle.
// Datapath (A = SAMPLE_BITS + 7, N = A + 1):
//   Each channel is summed bit-serially through its A-bit accumulator shift
//   register, and an average comes from the shared restoring divider with an
//   N-bit numerator. A new request is taken once the previous frame has left
//   its last result in the output register.
// Reset: windows return to 100, 50, 20, 10, 4, 2, 1, 1; accumulators and
//   counts clear; the output register empties. No clearing pass is needed.
// Stall: results wait in the output register plus one pending slot; the
//   sequencer holds while both are full and the receiver stalls.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_boxcar_decimator #(
   parameter int CHANNELS    = 8,
   parameter int MAX_WINDOW  = 100,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   mbd_req_if.sink                          req_bus,
   mbd_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [mbd_pkg::REG_IDX_BITS-1:0] csr_index,
   input  logic [mbd_pkg::WIN_BITS-1:0]     csr_wdata
);
   import mbd_pkg::*;

   // accumulator holds up to WIN_MAX samples; numerator is 2*|sum| + w
   localparam int ACC_BITS    = SAMPLE_BITS + WIN_BITS;
   localparam int NUM_BITS    = ACC_BITS + 1;
   localparam int DEN_BITS    = WIN_BITS + 1;
   localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int STEP_BITS   = $clog2(ACC_BITS);
   localparam logic [WIN_BITS-1:0] WIN_CAP =
      WIN_BITS'((MAX_WINDOW > WIN_MAX) ? WIN_MAX : MAX_WINDOW);
   localparam logic [CH_IDX_BITS-1:0] LAST_CH = CH_IDX_BITS'(CHANNELS - 1);

   // configuration and per-channel state
   logic [WIN_BITS-1:0]    window_ff [CHANNELS];
   logic [ACC_BITS-1:0]    acc_ff    [CHANNELS];
   logic [WIN_BITS-1:0]    cnt_ff    [CHANNELS];
   logic [SAMPLE_BITS-1:0] sample_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] frame_w   [REG_COUNT];

   // sequencer
   seq_state_type          state_ff, state_in;
   seq_ctl_type            ctl;
   logic                   req_ready;
   logic [CH_IDX_BITS-1:0] ch_ff;
   logic [WIN_BITS-1:0]    weff_ff;

   // bit-serial adder
   logic [ACC_BITS-1:0]    acc_sh_ff;
   logic [SAMPLE_BITS-1:0] smp_sh_ff;
   logic                   carry_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic                   sum_bit;
   logic                   carry_in;

   // window check and divider hookup
   logic [WIN_BITS-1:0]    win_sel;
   logic [WIN_BITS-1:0]    win_eff;
   logic [WIN_BITS-1:0]    cnt_next;
   logic                   hits;
   logic [ACC_BITS-1:0]    mag_w;
   logic [NUM_BITS-1:0]    num_w;
   logic [DEN_BITS-1:0]    den_w;
   logic                   div_done;
   logic [NUM_BITS-1:0]    div_quot;
   logic [SAMPLE_BITS-1:0] q_low;
   logic [SAMPLE_BITS-1:0] avg_w;
   logic                   sign_ff;

   // pending result and output register
   logic                     pend_valid_ff;
   logic [CH_FIELD_BITS-1:0] pend_channel_ff;
   logic [SAMPLE_BITS-1:0]   pend_average_ff;
   logic                     rsp_valid_ff;
   logic [CH_FIELD_BITS-1:0] rsp_channel_ff;
   logic [SAMPLE_BITS-1:0]   rsp_average_ff;
   logic                     rsp_last_ff;
   logic                     out_free;

   always_comb begin
      frame_w[0] = req_bus.sample_ch0;
      frame_w[1] = req_bus.sample_ch1;
      frame_w[2] = req_bus.sample_ch2;
      frame_w[3] = req_bus.sample_ch3;
      frame_w[4] = req_bus.sample_ch4;
      frame_w[5] = req_bus.sample_ch5;
      frame_w[6] = req_bus.sample_ch6;
      frame_w[7] = req_bus.sample_ch7;
   end

   // oversized windows act as the cap
   assign win_sel = window_ff[ch_ff];
   assign win_eff = (win_sel > WIN_CAP) ? WIN_CAP : win_sel;

   // one full-adder bit per cycle, LSB first
   assign sum_bit  = acc_sh_ff[0] ^ smp_sh_ff[0] ^ carry_ff;
   assign carry_in = (acc_sh_ff[0] & smp_sh_ff[0]) | (acc_sh_ff[0] & carry_ff) |
                     (smp_sh_ff[0] & carry_ff);

   // count never wraps: it stays below the previous window before the add
   assign cnt_next = cnt_ff[ch_ff] + WIN_BITS'(1);
   assign hits     = cnt_next >= weff_ff;

   // round half away from zero: floor((2*|sum| + w) / (2*w)), sign restored
   assign mag_w = acc_sh_ff[ACC_BITS-1] ? ((~acc_sh_ff) + ACC_BITS'(1)) : acc_sh_ff;
   assign num_w = {mag_w, 1'b0} + NUM_BITS'(weff_ff);
   assign den_w = {weff_ff, 1'b0};
   assign q_low = div_quot[SAMPLE_BITS-1:0];
   assign avg_w = sign_ff ? ((~q_low) + SAMPLE_BITS'(1)) : q_low;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   mbd_serial_div #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (DEN_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.emit),
      .numer    (num_w),
      .denom    (den_w),
      .done     (div_done),
      .quotient (div_quot)
   );

   // sequencer: walk the channels of one frame, hold the newest result back
   // until the next one (or the frame end) tells whether it is the last
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               ctl.take_frame = 1'b1;
               state_in       = SEQ_LOAD;
            end
         end
         SEQ_LOAD: begin
            // disabled channel: drop its partial window so a later enable starts fresh
            if (win_sel == '0) begin
               ctl.clear_ch = 1'b1;
               state_in     = SEQ_NEXT;
            end else begin
               ctl.load_ch = 1'b1;
               state_in    = SEQ_ADD;
            end
         end
         SEQ_ADD: begin
            ctl.add_step = 1'b1;
            if (step_ff == '0) begin
               state_in = SEQ_CHECK;
            end
         end
         SEQ_CHECK: begin
            if (hits) begin
               ctl.emit     = 1'b1;
               ctl.clear_ch = 1'b1;
               state_in     = SEQ_DIV;
            end else begin
               ctl.commit = 1'b1;
               state_in   = SEQ_NEXT;
            end
         end
         SEQ_DIV: begin
            if (div_done) begin
               state_in = SEQ_PUSH;
            end
         end
         SEQ_PUSH: begin
            if (!pend_valid_ff || out_free) begin
               ctl.push_out  = pend_valid_ff;
               ctl.pend_load = 1'b1;
               state_in      = SEQ_NEXT;
            end
         end
         SEQ_NEXT: begin
            if (ch_ff == LAST_CH) begin
               state_in = SEQ_FLUSH;
            end else begin
               ctl.next_ch = 1'b1;
               state_in    = SEQ_LOAD;
            end
         end
         SEQ_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = SEQ_IDLE;
            end else if (out_free) begin
               ctl.flush = 1'b1;
               state_in  = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            window_ff[i] <= WINDOW_RESET[i];
            acc_ff[i]    <= '0;
            cnt_ff[i]    <= '0;
         end
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // writes beyond the implemented channels are ignored
         if (csr_we && (int'(csr_index) < CHANNELS)) begin
            window_ff[csr_index[CH_IDX_BITS-1:0]] <= csr_wdata;
         end
         if (ctl.clear_ch) begin
            acc_ff[ch_ff] <= '0;
            cnt_ff[ch_ff] <= '0;
         end else if (ctl.commit) begin
            acc_ff[ch_ff] <= acc_sh_ff;
            cnt_ff[ch_ff] <= cnt_next;
         end
         if (ctl.pend_load) begin
            pend_valid_ff <= 1'b1;
         end else if (ctl.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (ctl.push_out || ctl.flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (ctl.take_frame) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sample_ff[i] <= frame_w[i];
         end
         ch_ff <= '0;
      end else if (ctl.next_ch) begin
         ch_ff <= ch_ff + CH_IDX_BITS'(1);
      end
      if (ctl.load_ch) begin
         weff_ff   <= win_eff;
         acc_sh_ff <= acc_ff[ch_ff];
         smp_sh_ff <= sample_ff[ch_ff];
         carry_ff  <= 1'b0;
         step_ff   <= STEP_BITS'(ACC_BITS - 1);
      end else if (ctl.add_step) begin
         // sign-extend the sample by replicating its top bit as it shifts out
         acc_sh_ff <= {sum_bit, acc_sh_ff[ACC_BITS-1:1]};
         smp_sh_ff <= {smp_sh_ff[SAMPLE_BITS-1], smp_sh_ff[SAMPLE_BITS-1:1]};
         carry_ff  <= carry_in;
         step_ff   <= step_ff - STEP_BITS'(1);
      end
      if (ctl.emit) begin
         sign_ff <= acc_sh_ff[ACC_BITS-1];
      end
      if (ctl.pend_load) begin
         pend_channel_ff <= CH_FIELD_BITS'(ch_ff);
         pend_average_ff <= avg_w;
      end
      if (ctl.push_out || ctl.flush) begin
         rsp_channel_ff <= pend_channel_ff;
         rsp_average_ff <= pend_average_ff;
         rsp_last_ff    <= ctl.flush;
      end
   end

   assign req_bus.ready   = req_ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.channel = rsp_channel_ff;
   assign rsp_bus.average = rsp_average_ff;
   assign rsp_bus.last    = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/mbd_checker.sv
// Port-level checks for the boxcar decimator, bound to its top level.
// Depends on multichannel_boxcar_decimator_defines.svh, mbd_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "multichannel_boxcar_decimator_defines.svh"

module mbd_checker #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [mbd_pkg::CH_FIELD_BITS-1:0] rsp_channel,
   input logic [SAMPLE_BITS-1:0]           rsp_average,
   input logic                             rsp_last
);

   // a stalled response holds
   `MBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_channel) && $stable(rsp_average) && $stable(rsp_last))

   // results only name implemented channels
   `MBD_ASSERT_HOLDS(a_rsp_channel_range, clock, reset, rsp_valid, int'(rsp_channel) < CHANNELS)

   // one frame at a time: no request taken right after another
   `MBD_ASSERT_NEXT(a_one_frame, clock, reset, req_valid && req_ready, !req_ready)

   // reset empties the output and leaves the block ready
   `MBD_ASSERT_AFTER_RESET(a_reset_quiet, clock, reset, !rsp_valid && req_ready)

endmodule

bind multichannel_boxcar_decimator mbd_checker #(
   .CHANNELS    (CHANNELS),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_mbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_channel (rsp_bus.channel),
   .rsp_average (rsp_bus.average),
   .rsp_last    (rsp_bus.last)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for multichannel_boxcar_decimator: directed and random frames are
// scored against an in-bench boxcar-average model, with random pacing on both ports.
// Depends on mbd_pkg, mbd_req_if, mbd_rsp_if and the decimator RTL.

module tb_top;
   import mbd_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int CHAN_COUNT    = 8;
   localparam int WIN_CAP       = 100;    // windows above this act as this
   localparam int SETTLE_CYCLES = 600;    // longer than a frame with eight results
   localparam int HOLD_CYCLES   = 3000;   // long receiver hold-off for back-pressure
   localparam int QUIET_LIMIT   = 20000;  // cycles with no handshake before giving up
   localparam int RANDOM_FRAMES = 190;

   // one request: sample of channel 0 sits at index 0 (leftmost in a concatenation)
   typedef logic [0:CHAN_COUNT-1][15:0] frame_type;

   typedef struct packed {
      logic [CH_FIELD_BITS-1:0] channel;
      logic signed [15:0]       average;
      logic                     last;
   } average_type;

   typedef enum logic [REG_IDX_BITS-1:0] {
      WIN_CH0, WIN_CH1, WIN_CH2, WIN_CH3, WIN_CH4, WIN_CH5, WIN_CH6, WIN_CH7
   } window_reg_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [REG_IDX_BITS-1:0] csr_index;
   logic [WIN_BITS-1:0] csr_wdata;

   mbd_req_if #(.SAMPLE_BITS(16)) req_if ();
   mbd_rsp_if #(.SAMPLE_BITS(16)) rsp_if ();

   multichannel_boxcar_decimator #(
      .CHANNELS(8),
      .MAX_WINDOW(100),
      .SAMPLE_BITS(16)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Boxcar model state: window per channel, running sum and sample count
   logic [WIN_BITS-1:0] window_len [CHAN_COUNT];
   logic signed [23:0]  chan_sum   [CHAN_COUNT];
   logic [WIN_BITS-1:0] chan_count [CHAN_COUNT];
   average_type         expected_averages [$];

   int frames_sent   = 0;
   int averages_seen = 0;
   int fail_count    = 0;
   int settings_used = 0;

   // sender pacing
   bit pacing_on  = 1'b0;
   int burst_left = 0;

   // receiver stall pattern and hold-off bookkeeping
   logic [15:0] stall_pattern   = 16'hffff;
   logic [3:0]  pattern_pos     = 4'd0;
   int          hold_left       = 0;
   int          holds_requested = 0;
   int          holds_served    = 0;

   // Round half away from zero on the magnitude, then reapply the sign.
   // Keep the low 16 bits: a lowered window can push the quotient out of range.
   function automatic logic [15:0] rounded_average(input logic signed [23:0] sum,
                                                   input int w);
      int mag;
      int q;
      mag = (sum < 0) ? -int'(sum) : int'(sum);
      q = (2 * mag + w) / (2 * w);
      if (sum < 0)
         q = -q;
      return q[15:0];
   endfunction

   // Advance the model by one accepted request and queue the averages it causes.
   task automatic predict_averages(input frame_type frame);
      average_type found [CHAN_COUNT];
      average_type item;
      int          n;
      int          w;
      n = 0;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         if (window_len[c] == '0) begin
            // disabled: drop the partial window so a later enable starts clean
            chan_sum[c]   = '0;
            chan_count[c] = '0;
         end else begin
            w = (window_len[c] > WIN_CAP) ? WIN_CAP : int'(window_len[c]);
            chan_sum[c]   = chan_sum[c] + $signed(frame[c]);
            chan_count[c] = chan_count[c] + 1'b1;
            // >= covers a window lowered below the samples already taken
            if (chan_count[c] >= w) begin
               item.channel = CH_FIELD_BITS'(c);
               item.average = rounded_average(chan_sum[c], w);
               item.last    = 1'b0;
               found[n]     = item;
               n++;
               chan_sum[c]   = '0;
               chan_count[c] = '0;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         item      = found[i];
         item.last = (i == n - 1);
         expected_averages.push_back(item);
      end
   endtask

   // Write one window register; the model follows at the same edge.
   task automatic write_window(input window_reg_type idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= WIN_BITS'(value);
      @(posedge clock);
      window_len[idx] = WIN_BITS'(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Offer one request and hold it until the block takes it.
   task automatic send_frame(input frame_type frame);
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.sample_ch0 <= frame[0];
      req_if.sample_ch1 <= frame[1];
      req_if.sample_ch2 <= frame[2];
      req_if.sample_ch3 <= frame[3];
      req_if.sample_ch4 <= frame[4];
      req_if.sample_ch5 <= frame[5];
      req_if.sample_ch6 <= frame[6];
      req_if.sample_ch7 <= frame[7];
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      predict_averages(frame);
      frames_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Send in bursts; between bursts drop valid for a short or a long gap.
   task automatic send_paced(input frame_type frame);
      int gap;
      if (pacing_on) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0)
               gap = $urandom_range(20, 450);
            else
               gap = $urandom_range(1, 8);
            pause_sender(gap);
            burst_left = $urandom_range(1, 10);
         end
         burst_left--;
      end
      send_frame(frame);
   endtask

   // Drop valid, drain every pending average, then let a silent frame finish.
   task automatic settle_block();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_averages.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic frame_type random_frame();
      frame_type f;
      for (int c = 0; c < CHAN_COUNT; c++)
         case ($urandom_range(0, 9))
            0:       f[c] = 16'h7fff;
            1:       f[c] = 16'h8000;
            2:       f[c] = 16'($urandom_range(0, 8) - 4);
            default: f[c] = 16'($urandom);
         endcase
      return f;
   endfunction

   // Mostly short windows so averages come often; some disabled, full and oversized.
   function automatic int random_window();
      case ($urandom_range(0, 15))
         0, 1:    return 0;
         2:       return WIN_CAP;
         3:       return $urandom_range(WIN_CAP + 1, (1 << WIN_BITS) - 1);
         4:       return $urandom_range(9, 40);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   function automatic logic [15:0] next_stall_pattern();
      case ($urandom_range(0, 5))
         0, 1:    return 16'hffff;                 // no stalls for a while
         2:       return 16'h0001;                 // long stall
         default: return 16'($urandom) | 16'($urandom) | 16'h0001;
      endcase
   endfunction

   // Receiver: follow the stall pattern, or hold off completely when asked.
   always @(negedge clock) begin
      if (holds_served != holds_requested) begin
         holds_served <= holds_requested;
         hold_left    <= HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= stall_pattern[pattern_pos];
         pattern_pos  <= pattern_pos + 1'b1;
         if (pattern_pos == 4'hf)
            stall_pattern <= next_stall_pattern();
      end
   end

   // Score every accepted average against the oldest one predicted.
   always @(posedge clock) begin : score_averages
      average_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         averages_seen++;
         if (expected_averages.size() == 0) begin
            $error("unexpected average: channel %0d average %0d last %0b",
                   rsp_if.channel, $signed(rsp_if.average), rsp_if.last);
            fail_count++;
         end else begin
            want = expected_averages.pop_front();
            if (rsp_if.channel !== want.channel) begin
               $error("channel: expected %0d, actual %0d", want.channel, rsp_if.channel);
               fail_count++;
            end
            if (rsp_if.average !== want.average) begin
               $error("average: expected %0d, actual %0d",
                      $signed(want.average), $signed(rsp_if.average));
               fail_count++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_if.last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run if neither port moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Reset windows, extreme samples and a mixed bit pattern.
   task automatic test_reset_windows();
      pacing_on = 1'b0;
      send_frame({8{16'h7fff}});
      send_frame({8{16'h8000}});
      send_frame({8{16'h0000}});
      send_frame({16'h0001, 16'hffff, 16'h5555, 16'haaaa,
                  16'h00ff, 16'hff00, 16'h8001, 16'h7ffe});
   endtask

   // Sums that land exactly on a half, both signs, plus thirds and quarters.
   task automatic test_rounding();
      settle_block();
      write_window(WIN_CH0, 2);
      write_window(WIN_CH1, 2);
      write_window(WIN_CH2, 3);
      write_window(WIN_CH3, 3);
      write_window(WIN_CH4, 4);
      write_window(WIN_CH5, 4);
      write_window(WIN_CH6, 1);
      write_window(WIN_CH7, 1);
      settings_used++;
      send_frame({16'sd1, -16'sd1, 16'sd1, -16'sd2, 16'sd1, -16'sd1, 16'sd3, -16'sd3});
      send_frame({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, -16'sd1, -16'sd4, 16'sd4});
      send_frame({16'sd5, -16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h7fff, 16'h8000});
      send_frame({16'h7fff, 16'h8000, 16'sd2, 16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
   endtask

   // Disable mid-window, re-enable fresh, and lower a window below its count.
   task automatic test_disable_and_lower();
      settle_block();
      write_window(WIN_CH0, 10);
      write_window(WIN_CH1, 0);
      write_window(WIN_CH2, 5);
      settings_used++;
      send_frame({8{16'sd25}});
      send_frame({8{-16'sd7}});
      send_frame({8{16'sd100}});
      settle_block();
      // three samples taken, window now two: emit at once over the new window
      write_window(WIN_CH0, 2);
      write_window(WIN_CH1, 3);
      write_window(WIN_CH2, 0);
      settings_used++;
      send_frame({8{16'sd9}});
      send_frame({8{-16'sd4}});
      settle_block();
      write_window(WIN_CH2, 2);
      settings_used++;
      send_frame({8{16'sd3}});
      send_frame({8{16'sd4}});
   endtask

   // Every channel off, then every channel at the largest register value.
   task automatic test_window_extremes();
      settle_block();
      for (int c = 0; c < CHAN_COUNT; c++)
         write_window(window_reg_type'(c), 0);
      settings_used++;
      send_frame({8{16'h7fff}});
      send_frame({8{16'h8000}});
      settle_block();
      for (int c = 0; c < CHAN_COUNT; c++)
         write_window(window_reg_type'(c), (1 << WIN_BITS) - 1);
      settings_used++;
      send_frame({8{16'h7fff}});
      send_frame({8{16'h8000}});
   endtask

   // Eight averages per request while the receiver holds off: the output
   // slots fill, the sequencer stalls, and requests back up behind it.
   task automatic test_backpressure();
      settle_block();
      for (int c = 0; c < CHAN_COUNT; c++)
         write_window(window_reg_type'(c), 1);
      settings_used++;
      pacing_on = 1'b0;
      holds_requested++;
      repeat (6) send_frame(random_frame());
   endtask

   // Random window settings per phase, random samples, random pacing.
   task automatic test_random_settings();
      int random_sent;
      int phase_len;
      random_sent = 0;
      while (random_sent < RANDOM_FRAMES) begin
         settle_block();
         for (int c = 0; c < CHAN_COUNT; c++)
            write_window(window_reg_type'(c), random_window());
         settings_used++;
         pacing_on  = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         phase_len  = $urandom_range(10, 40);
         repeat (phase_len) begin
            send_paced(random_frame());
            random_sent++;
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.sample_ch0 = '0;
      req_if.sample_ch1 = '0;
      req_if.sample_ch2 = '0;
      req_if.sample_ch3 = '0;
      req_if.sample_ch4 = '0;
      req_if.sample_ch5 = '0;
      req_if.sample_ch6 = '0;
      req_if.sample_ch7 = '0;
      rsp_if.ready      = 1'b0;

      // model after reset: default windows, empty accumulators
      window_len[0] = 7'd100;
      window_len[1] = 7'd50;
      window_len[2] = 7'd20;
      window_len[3] = 7'd10;
      window_len[4] = 7'd4;
      window_len[5] = 7'd2;
      window_len[6] = 7'd1;
      window_len[7] = 7'd1;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         chan_sum[c]   = '0;
         chan_count[c] = '0;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_windows();
      test_rounding();
      test_disable_and_lower();
      test_window_extremes();
      test_backpressure();
      test_random_settings();
      settle_block();

      $display("Covered %0d frames and %0d averages over %0d window settings,",
               frames_sent, averages_seen, settings_used + 1);
      $display("including disabled, oversized and lowered windows and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
